// File: rtl/wpcs_pkg.sv
// Package for the wheel power current scaler: payload words and model constants.
// Depends on nothing; used by wheel_power_current_scaler_core.
`default_nettype none
package wpcs_pkg;

	typedef struct packed {
		logic signed [15:0] motor0_current;
		logic signed [15:0] motor0_speed;
		logic signed [15:0] motor1_current;
		logic signed [15:0] motor1_speed;
	} req_t;

	typedef struct packed {
		logic signed [19:0] current_scale;
		logic        [19:0] predicted_power;
		logic               over_limit;
		logic               root_found;
	} rsp_t;

	localparam int PW = 56;

	localparam logic signed [PW-1:0] KT_Q40 = 56'sd2195604;
	localparam logic signed [PW-1:0] K0_Q40 = 56'sd159759;
	localparam logic signed [PW-1:0] R0_Q40 = 56'sd135240;
	localparam logic signed [PW-1:0] P0_Q40 = 56'sd3387595325178;

	localparam logic signed [19:0] ONE_Q16   = 20'sd65536;
	localparam logic signed [19:0] SCALE_MAX = 20'sd524287;
	localparam logic signed [19:0] SCALE_MIN = -20'sd524288;
	localparam logic        [19:0] POWER_MAX = 20'hFFFFF;
	localparam logic        [19:0] LIMIT_RST = 20'd43520;

endpackage
`default_nettype wire

// File: rtl/wheel_power_current_scaler_core.sv
// Top level of the wheel power current scaler: power prediction and quadratic scale solve.
// Depends on wpcs_pkg for the payload words and the model constants.
`default_nettype none
// Each word carries the current and speed of two wheel motors and gives one result word:
// summed non-negative predicted power and, at or over the configured limit, the current
// scale that brings it to the limit (one below it). One word enters every cycle unless
// the output stalls; the depth is set by the 32-step square root and the 20-bit
// divider, each cut into two steps a stage. All stages advance together, so a stalled
// result stalls the input only while the output is full and not taken.
module wheel_power_current_scaler_core
	import wpcs_pkg::*;
#(
	parameter int MOTOR_COUNT = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp
);

	localparam int NM = (MOTOR_COUNT < 2) ? MOTOR_COUNT : 2;
	localparam int SQ_ST = 16;
	localparam int DV_ST = 10;

	typedef struct packed {
		logic               over;
		logic               found;
		logic               azero;
		logic [19:0]        pp;
		logic signed [30:0] a;
		logic signed [30:0] b;
		logic [63:0]        v;
		logic [63:0]        root;
	} sq_t;

	typedef struct packed {
		logic        over;
		logic        found;
		logic        azero;
		logic [19:0] pp;
		logic        neg;
		logic        ovf;
		logic [31:0] den;
		logic [49:0] rem;
		logic [19:0] q;
	} dv_t;

	function automatic sq_t sq_step(sq_t x, int j);
		logic [63:0] bv;
		logic [63:0] t;
		sq_t y;
		y = x;
		bv = 64'd1 << (62 - 2 * j);
		t = x.root + bv;
		if (x.v >= t) begin
			y.v = x.v - t;
			y.root = (x.root >> 1) + bv;
		end else begin
			y.root = x.root >> 1;
		end
		return y;
	endfunction

	function automatic dv_t dv_step(dv_t x, int j);
		logic [51:0] sub;
		dv_t y;
		y = x;
		sub = 52'(x.den) << j;
		if ({2'b00, x.rem} >= sub) begin
			y.rem = x.rem - sub[49:0];
			y.q[j] = 1'b1;
		end
		return y;
	endfunction

	function automatic logic [54:0] mag(logic signed [PW-1:0] x);
		logic [PW-1:0] m;
		m = x[PW-1] ? PW'(-x) : PW'(x);
		return m[54:0];
	endfunction

	logic               en;
	logic [19:0]        limit_q;
	logic signed [15:0] cur [2];
	logic signed [15:0] spd [2];

	logic signed [31:0] cs_s1 [NM];
	logic signed [31:0] ss_s1 [NM];
	logic signed [31:0] cc_s1 [NM];
	logic signed [PW-1:0] tq_s2 [NM];
	logic signed [PW-1:0] ls_s2 [NM];
	logic signed [PW-1:0] lc_s2 [NM];
	logic signed [PW-1:0] p_s3 [NM];
	logic signed [PW-1:0] a_s3, b_s3, c_s3;
	logic signed [PW-1:0] total_s4, a_s4, b_s4, c_s4;
	logic signed [PW-1:0] a_s5, b_s5, c_s5;
	logic                 over_s5, over_s6, over_s7;
	logic [19:0]          pp_s5, pp_s6, pp_s7;
	logic [54:0]          m_s5;
	logic signed [30:0]   a_s6, b_s6, c_s6, a_s7, b_s7;
	logic signed [63:0]   bb_s7, ac_s7;
	logic [35:0]          vld_s;

	sq_t sqrt_s [SQ_ST+1];
	dv_t div_s [DV_ST+1];

	logic signed [PW-1:0] s3_a, s3_b, s3_c, s4_t;
	logic signed [PW-1:0] lim_w;
	logic [4:0]           s6_sh;
	logic [54:0]          s5_m;
	logic signed [63:0]   s8_d;
	logic signed [34:0]   num_w;
	logic [34:0]          num_mag;
	logic [49:0]          num_n;
	logic signed [19:0]   k_w;

	assign cur[0] = req.motor0_current;
	assign spd[0] = req.motor0_speed;
	assign cur[1] = req.motor1_current;
	assign spd[1] = req.motor1_speed;

	assign en = !vld_s[35] || rsp_ready;
	assign req_ready = en;
	assign lim_w = $signed({4'b0000, limit_q, 32'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[34:0], req_valid};
		end
	end

	always_comb begin
		s3_a = '0;
		s3_b = '0;
		s3_c = PW'(NM) * P0_Q40 - lim_w;
		for (int i = 0; i < NM; i++) begin
			s3_a = s3_a + lc_s2[i];
			s3_b = s3_b + tq_s2[i];
			s3_c = s3_c + ls_s2[i];
		end
		s4_t = '0;
		for (int i = 0; i < NM; i++) begin
			if (!p_s3[i][PW-1]) begin
				s4_t = s4_t + p_s3[i];
			end
		end
		s5_m = mag(a_s4);
		if (mag(b_s4) > s5_m) begin
			s5_m = mag(b_s4);
		end
		if (mag(c_s4) > s5_m) begin
			s5_m = mag(c_s4);
		end
		s6_sh = '0;
		for (int i = 30; i < 55; i++) begin
			if (m_s5[i]) begin
				s6_sh = 5'(i - 29);
			end
		end
		s8_d = bb_s7 - (ac_s7 <<< 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NM; i++) begin
				cs_s1[i] <= 32'(cur[i]) * 32'(spd[i]);
				ss_s1[i] <= 32'(spd[i]) * 32'(spd[i]);
				cc_s1[i] <= 32'(cur[i]) * 32'(cur[i]);
				tq_s2[i] <= PW'(cs_s1[i]) * KT_Q40;
				ls_s2[i] <= PW'(ss_s1[i]) * K0_Q40;
				lc_s2[i] <= PW'(cc_s1[i]) * R0_Q40;
				p_s3[i]  <= tq_s2[i] + ls_s2[i] + lc_s2[i] + P0_Q40;
			end
			a_s3 <= s3_a;
			b_s3 <= s3_b;
			c_s3 <= s3_c;
			total_s4 <= s4_t;
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			c_s4 <= c_s3;
			over_s5 <= (total_s4 >= lim_w);
			pp_s5 <= (total_s4[PW-1:32] > PW'(POWER_MAX)) ? POWER_MAX : total_s4[51:32];
			m_s5 <= s5_m;
			a_s5 <= a_s4;
			b_s5 <= b_s4;
			c_s5 <= c_s4;
			over_s6 <= over_s5;
			pp_s6 <= pp_s5;
			a_s6 <= 31'(a_s5 >>> s6_sh);
			b_s6 <= 31'(b_s5 >>> s6_sh);
			c_s6 <= 31'(c_s5 >>> s6_sh);
			over_s7 <= over_s6;
			pp_s7 <= pp_s6;
			a_s7 <= a_s6;
			b_s7 <= b_s6;
			bb_s7 <= 64'(b_s6) * 64'(b_s6);
			ac_s7 <= 64'(a_s6) * 64'(c_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s[0].over  <= over_s7;
			sqrt_s[0].found <= !s8_d[63];
			sqrt_s[0].azero <= (a_s7 == '0);
			sqrt_s[0].pp    <= pp_s7;
			sqrt_s[0].a     <= a_s7;
			sqrt_s[0].b     <= b_s7;
			sqrt_s[0].v     <= s8_d[63] ? 64'd0 : 64'(s8_d);
			sqrt_s[0].root  <= '0;
		end
	end

	for (genvar t = 0; t < SQ_ST; t++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[t+1] <= sq_step(sq_step(sqrt_s[t], 2 * t), 2 * t + 1);
			end
		end
	end

	always_comb begin
		if (sqrt_s[SQ_ST].found) begin
			num_w = -35'(sqrt_s[SQ_ST].b) + $signed({1'b0, sqrt_s[SQ_ST].root[33:0]});
		end else begin
			num_w = -35'(sqrt_s[SQ_ST].b);
		end
		num_mag = num_w[34] ? 35'(-num_w) : 35'(num_w);
		num_n = {num_mag[33:0], 16'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].over  <= sqrt_s[SQ_ST].over;
			div_s[0].found <= sqrt_s[SQ_ST].found;
			div_s[0].azero <= sqrt_s[SQ_ST].azero;
			div_s[0].pp    <= sqrt_s[SQ_ST].pp;
			div_s[0].neg   <= num_w[34];
			div_s[0].den   <= {sqrt_s[SQ_ST].a, 1'b0};
			div_s[0].ovf   <= {2'b00, num_n} >= (52'({sqrt_s[SQ_ST].a, 1'b0}) << 20);
			div_s[0].rem   <= num_n;
			div_s[0].q     <= '0;
		end
	end

	for (genvar t = 0; t < DV_ST; t++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[t+1] <= dv_step(dv_step(div_s[t], 19 - 2 * t), 18 - 2 * t);
			end
		end
	end

	always_comb begin
		priority if (!div_s[DV_ST].over) begin
			k_w = ONE_Q16;
		end else if (div_s[DV_ST].azero) begin
			k_w = '0;
		end else if (div_s[DV_ST].ovf) begin
			k_w = div_s[DV_ST].neg ? SCALE_MIN : SCALE_MAX;
		end else if (div_s[DV_ST].neg) begin
			k_w = (div_s[DV_ST].q > 20'd524288) ? SCALE_MIN : $signed(-div_s[DV_ST].q);
		end else begin
			k_w = (div_s[DV_ST].q > 20'd524287) ? SCALE_MAX : $signed(div_s[DV_ST].q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.current_scale   <= k_w;
			rsp.predicted_power <= div_s[DV_ST].pp;
			rsp.over_limit      <= div_s[DV_ST].over;
			rsp.root_found      <= div_s[DV_ST].over && div_s[DV_ST].found;
		end
	end

	assign rsp_valid = vld_s[35];

`ifndef SYNTHESIS
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("Input ready does not follow the output stall.");
	a_unscaled_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.over_limit |-> rsp.current_scale == ONE_Q16 && !rsp.root_found)
		else $error("Unscaled word has a scale other than one.");
	a_root_needs_over: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.root_found |-> rsp.over_limit)
		else $error("Root reported on a word under the limit.");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("Stalled result word changed.");
`endif

endmodule
`default_nettype wire
